/* rtl/cac_pkg.sv */
`default_nettype none

package cac_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // Register indexes, taken from paddr[3:2]
    localparam logic [REG_IDX_W-1:0] REG_COLLISION_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NEAR_MISS_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TREND_BAND      = 2'd2;

    // Encounter classification codes
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEAR_MISS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COLLISION = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic first_sample;
        logic clear_counts;
    } t_step_flags;

endpackage

`default_nettype wire

/* rtl/cac_in_if.sv */
`default_nettype none

interface cac_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic                          first_sample;
    logic                          clear_counts;
    logic signed [COORD_WIDTH-1:0] xa;
    logic signed [COORD_WIDTH-1:0] ya;
    logic signed [COORD_WIDTH-1:0] xb;
    logic signed [COORD_WIDTH-1:0] yb;

    modport source (
        output valid, first_sample, clear_counts, xa, ya, xb, yb,
        input  ready
    );

    modport sink (
        input  valid, first_sample, clear_counts, xa, ya, xb, yb,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/cac_out_if.sv */
`default_nettype none

interface cac_out_if #(
    parameter int DIST_WIDTH  = 25,
    parameter int COUNT_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [DIST_WIDTH-1:0]  separation;
    logic [1:0]             encounter_kind;
    logic [COUNT_WIDTH-1:0] near_miss_total;
    logic [COUNT_WIDTH-1:0] collision_total;

    modport source (
        output valid, separation, encounter_kind, near_miss_total, collision_total,
        input  ready
    );

    modport sink (
        input  valid, separation, encounter_kind, near_miss_total, collision_total,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/cac_root.sv */
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle.
module cac_root #(
    parameter int W = 25
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2*W-1:0] i_radicand,
    output logic                o_done,
    output logic [W-1:0]        o_root
);
    localparam int CNT_W = $clog2(W);

    logic [2*W-1:0] r_rad;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [CNT_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [W+2:0]   shifted;
    logic [W+2:0]   trial;
    logic           take;
    logic [W+2:0]   diff;

    // Bring down the next two radicand bits and test the trial divisor
    assign shifted = {r_rem[W:0], r_rad[2*W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign take    = (shifted >= trial);
    assign diff    = shifted - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(W - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*W-3:0], 2'b00};
            r_cnt  <= r_cnt + CNT_W'(1);
            if (take) begin
                r_rem  <= diff[W+1:0];
                r_root <= {r_root[W-2:0], 1'b1};
            end else begin
                r_rem  <= shifted[W+1:0];
                r_root <= {r_root[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

`default_nettype wire

/* rtl/cac_track.sv */
`default_nettype none

// Distance trend, closest approach and encounter counters.
module cac_track #(
    parameter int DIST_WIDTH  = 25,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_update,
    input  wire cac_pkg::t_step_flags      i_flags,
    input  wire logic [DIST_WIDTH-1:0]     i_dist,
    input  wire logic [DIST_WIDTH-1:0]     i_collision_limit,
    input  wire logic [DIST_WIDTH-1:0]     i_near_miss_limit,
    input  wire logic [DIST_WIDTH-1:0]     i_trend_band,
    output logic [cac_pkg::KIND_W-1:0]     o_kind,
    output logic [COUNT_WIDTH-1:0]         o_near_total,
    output logic [COUNT_WIDTH-1:0]         o_collision_total
);
    logic [DIST_WIDTH-1:0]  r_last, n_last;
    logic [DIST_WIDTH-1:0]  r_closest, n_closest;
    logic                   r_counted, n_counted;
    logic [COUNT_WIDTH-1:0] r_near, n_near;
    logic [COUNT_WIDTH-1:0] r_coll, n_coll;
    logic [cac_pkg::KIND_W-1:0] kind;

    logic                  ge;
    logic [DIST_WIDTH-1:0] mag;
    logic                  beyond;
    logic                  upd;

    assign ge     = (i_dist >= r_last);
    assign mag    = ge ? (i_dist - r_last) : (r_last - i_dist);
    assign beyond = (mag > i_trend_band);

    always_comb begin
        n_last    = r_last;
        n_closest = r_closest;
        n_counted = r_counted;
        n_near    = i_flags.clear_counts ? '0 : r_near;
        n_coll    = i_flags.clear_counts ? '0 : r_coll;
        kind      = cac_pkg::KIND_NONE;
        upd       = (mag >= i_trend_band);
        if (i_flags.first_sample) begin
            n_last    = i_dist;
            n_closest = i_dist;
            n_counted = 1'b0;
        end else begin
            if (beyond && !ge) begin
                // approaching: open a new encounter
                n_closest = i_dist;
                n_counted = 1'b0;
            end else if (beyond && ge) begin
                if (r_counted) begin
                    // hold previous distance once the encounter is counted
                    upd = 1'b0;
                end else begin
                    if (r_closest <= i_collision_limit) begin
                        n_coll = (n_coll == '1) ? n_coll : n_coll + COUNT_WIDTH'(1);
                        kind   = cac_pkg::KIND_COLLISION;
                    end else if (r_closest <= i_near_miss_limit) begin
                        n_near = (n_near == '1) ? n_near : n_near + COUNT_WIDTH'(1);
                        kind   = cac_pkg::KIND_NEAR_MISS;
                    end
                    n_counted = 1'b1;
                end
            end
            if (upd) begin
                n_last = i_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_closest <= '0;
            r_counted <= 1'b0;
            r_near    <= '0;
            r_coll    <= '0;
        end else if (i_update) begin
            r_last    <= n_last;
            r_closest <= n_closest;
            r_counted <= n_counted;
            r_near    <= n_near;
            r_coll    <= n_coll;
        end
    end

    assign o_kind            = kind;
    assign o_near_total      = n_near;
    assign o_collision_total = n_coll;
endmodule

`default_nettype wire

/* rtl/closest_approach_encounter_counter_top.sv */
`default_nettype none

// Closest-approach encounter counter for one pair of vehicles.
//
// Input channel i_item carries one time step: both vehicles' positions
// (signed, FRAC_BITS fractional bits) plus the first_sample and
// clear_counts flags. Output channel o_result returns one item per step:
// the separation (floor of the Euclidean distance), the encounter kind
// counted on this step and both saturating encounter totals. Both channels
// transfer an item when valid and ready are high at a rising clock edge.
// Thresholds sit in three APB registers at byte addresses 0, 4 and 8:
// collision limit, near-miss limit and trend band; write them while idle.
//
// Flow: an accepted item is worked in order: the shared multiplier squares
// dx, then dy; the square-root unit is started and produces one root bit
// per cycle (COORD_WIDTH + 1 bits); the sequencer waits for the root to
// finish, then updates the encounter state and loads the output register.
// A new item is accepted only in the idle state, once the previous item
// has reached the output register.
// The result sits in an output register, so the next item is accepted and
// worked while the receiver stalls; its update then waits until the held
// result has been taken.
// Reset (synchronous, active low) clears the trend and encounter state and
// the counters, drops any pending result and restores the default limits.
module closest_approach_encounter_counter_top #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    cac_in_if.sink                                i_item,
    cac_out_if.source                             o_result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [cac_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [cac_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [cac_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    localparam int DIST_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int RAD_WIDTH  = 2 * DIST_WIDTH;

    // Default thresholds: 2 m, 4 m and 0.1 m rounded to the nearest unit
    localparam logic [DIST_WIDTH-1:0] COLL_RESET =
        DIST_WIDTH'(64'd2 << FRAC_BITS);
    localparam logic [DIST_WIDTH-1:0] NEAR_RESET =
        DIST_WIDTH'(64'd4 << FRAC_BITS);
    localparam logic [DIST_WIDTH-1:0] BAND_RESET =
        DIST_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    cac_pkg::t_state r_state, n_state;

    // Configuration registers
    logic [DIST_WIDTH-1:0] r_coll_lim;
    logic [DIST_WIDTH-1:0] r_near_lim;
    logic [DIST_WIDTH-1:0] r_band;
    logic                  cfg_wr;
    logic [cac_pkg::REG_IDX_W-1:0] cfg_idx;

    // Step datapath
    logic [COORD_WIDTH-1:0] r_dx, r_dy;
    cac_pkg::t_step_flags   r_flags;
    logic [PROD_WIDTH-1:0]  r_prod;
    logic [PROD_WIDTH-1:0]  r_acc;
    logic [COORD_WIDTH-1:0] mul_op;
    logic [COORD_WIDTH:0]   diff_x, diff_y;
    logic [RAD_WIDTH-1:0]   radicand;

    // Sequencer outputs
    logic in_ready;
    logic mul_en;
    logic root_start;
    logic emit_fire;

    logic                  root_done;
    logic [DIST_WIDTH-1:0] root_val;

    logic [cac_pkg::KIND_W-1:0] trk_kind;
    logic [COUNT_WIDTH-1:0]     trk_near;
    logic [COUNT_WIDTH-1:0]     trk_coll;

    // Output register
    logic                       r_out_valid;
    logic [DIST_WIDTH-1:0]      r_sep;
    logic [cac_pkg::KIND_W-1:0] r_kind;
    logic [COUNT_WIDTH-1:0]     r_near_tot;
    logic [COUNT_WIDTH-1:0]     r_coll_tot;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[cac_pkg::REG_IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll_lim <= COLL_RESET;
            r_near_lim <= NEAR_RESET;
            r_band     <= BAND_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                cac_pkg::REG_COLLISION_LIMIT: r_coll_lim <= pwdata[DIST_WIDTH-1:0];
                cac_pkg::REG_NEAR_MISS_LIMIT: r_near_lim <= pwdata[DIST_WIDTH-1:0];
                cac_pkg::REG_TREND_BAND:      r_band     <= pwdata[DIST_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            cac_pkg::REG_COLLISION_LIMIT: prdata = cac_pkg::CFG_DATA_W'(r_coll_lim);
            cac_pkg::REG_NEAR_MISS_LIMIT: prdata = cac_pkg::CFG_DATA_W'(r_near_lim);
            cac_pkg::REG_TREND_BAND:      prdata = cac_pkg::CFG_DATA_W'(r_band);
            default:                      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cac_pkg::ST_IDLE: begin
                if (i_item.valid) n_state = cac_pkg::ST_MUL_X;
            end
            cac_pkg::ST_MUL_X:   n_state = cac_pkg::ST_MUL_Y;
            cac_pkg::ST_MUL_Y:   n_state = cac_pkg::ST_ROOT_GO;
            cac_pkg::ST_ROOT_GO: n_state = cac_pkg::ST_ROOT_WAIT;
            cac_pkg::ST_ROOT_WAIT: begin
                if (root_done) n_state = cac_pkg::ST_EMIT;
            end
            cac_pkg::ST_EMIT: begin
                // hold until the previous result has left the output register
                if (!r_out_valid || o_result.ready) n_state = cac_pkg::ST_IDLE;
            end
            default: n_state = cac_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        mul_en     = 1'b0;
        root_start = 1'b0;
        emit_fire  = 1'b0;
        unique case (r_state)
            cac_pkg::ST_IDLE:      in_ready   = 1'b1;
            cac_pkg::ST_MUL_X:     mul_en     = 1'b1;
            cac_pkg::ST_MUL_Y:     mul_en     = 1'b1;
            cac_pkg::ST_ROOT_GO:   root_start = 1'b1;
            cac_pkg::ST_ROOT_WAIT: ;
            cac_pkg::ST_EMIT:      emit_fire  = !r_out_valid || o_result.ready;
            default: ;
        endcase
    end

    assign i_item.ready = in_ready;

    // ---------------- capture and squares ----------------
    // Absolute coordinate differences fit COORD_WIDTH bits unsigned
    assign diff_x = {i_item.xa[COORD_WIDTH-1], i_item.xa}
                  - {i_item.xb[COORD_WIDTH-1], i_item.xb};
    assign diff_y = {i_item.ya[COORD_WIDTH-1], i_item.ya}
                  - {i_item.yb[COORD_WIDTH-1], i_item.yb};

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_dx    <= diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
            r_dy    <= diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
            r_flags <= '{first_sample: i_item.first_sample,
                         clear_counts: i_item.clear_counts};
        end
    end

    // One multiplier squares dx, then dy; keep dx squared in the accumulator
    assign mul_op = (r_state == cac_pkg::ST_MUL_X) ? r_dx : r_dy;

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_op * mul_op;
            r_acc  <= r_prod;
        end
    end

    assign radicand = RAD_WIDTH'({1'b0, r_acc} + {1'b0, r_prod});

    cac_root #(
        .W (DIST_WIDTH)
    ) u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (radicand),
        .o_done     (root_done),
        .o_root     (root_val)
    );

    cac_track #(
        .DIST_WIDTH  (DIST_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_update          (emit_fire),
        .i_flags           (r_flags),
        .i_dist            (root_val),
        .i_collision_limit (r_coll_lim),
        .i_near_miss_limit (r_near_lim),
        .i_trend_band      (r_band),
        .o_kind            (trk_kind),
        .o_near_total      (trk_near),
        .o_collision_total (trk_coll)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_sep      <= root_val;
            r_kind     <= trk_kind;
            r_near_tot <= trk_near;
            r_coll_tot <= trk_coll;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.separation      = r_sep;
    assign o_result.encounter_kind  = r_kind;
    assign o_result.near_miss_total = r_near_tot;
    assign o_result.collision_total = r_coll_tot;
endmodule

`default_nettype wire

/* rtl/cac_checker.sv */
`default_nettype none

module cac_checker #(
    parameter int DIST_WIDTH  = 25,
    parameter int COUNT_WIDTH = 16
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [DIST_WIDTH-1:0]      i_separation,
    input wire logic [cac_pkg::KIND_W-1:0] i_kind,
    input wire logic [COUNT_WIDTH-1:0]     i_near_total,
    input wire logic [COUNT_WIDTH-1:0]     i_coll_total
);
    // Drop any pending result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_separation)
            && $stable(i_kind) && $stable(i_near_total) && $stable(i_coll_total))
        else $error("stalled result changed");

    // One item at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // A counted collision shows in the collision total
    a_coll_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == cac_pkg::KIND_COLLISION) |-> (i_coll_total != '0))
        else $error("collision reported with zero total");
endmodule

bind closest_approach_encounter_counter_top cac_checker #(
    .DIST_WIDTH  (COORD_WIDTH + 1),
    .COUNT_WIDTH (COUNT_WIDTH)
) u_cac_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_separation (o_result.separation),
    .i_kind       (o_result.encounter_kind),
    .i_near_total (o_result.near_miss_total),
    .i_coll_total (o_result.collision_total)
);

`default_nettype wire

/* tb/closest_approach_encounter_counter_checker.sv */
`timescale 1ns / 100ps

module closest_approach_encounter_counter_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_item_valid,
    input  wire logic                           i_item_ready,
    input  wire logic                           i_first_sample,
    input  wire logic                           i_clear_counts,
    input  wire logic signed [23:0]             i_xa,
    input  wire logic signed [23:0]             i_ya,
    input  wire logic signed [23:0]             i_xb,
    input  wire logic signed [23:0]             i_yb,
    input  wire logic                           i_result_valid,
    input  wire logic                           i_result_ready,
    input  wire logic [24:0]                    i_separation,
    input  wire logic [cac_pkg::KIND_W-1:0]     i_encounter_kind,
    input  wire logic [15:0]                    i_near_miss_total,
    input  wire logic [15:0]                    i_collision_total,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic                           i_pready,
    input  wire logic [cac_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [cac_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_encounters
);

    localparam logic [24:0] DEFAULT_COLLISION = 25'd512;
    localparam logic [24:0] DEFAULT_NEAR_MISS = 25'd1024;
    localparam logic [24:0] DEFAULT_BAND      = 25'd26;
    localparam int          REPORT_CAP        = 40;

    typedef struct packed {
        logic [24:0]                separation;
        logic [cac_pkg::KIND_W-1:0] kind;
        logic [15:0]                near_total;
        logic [15:0]                collision_total;
    } t_step_outcome;

    // Thresholds as last written, and the encounter state they act on.
    logic [24:0] coll_limit;
    logic [24:0] near_limit;
    logic [24:0] band;
    logic [24:0] prev_dist;
    logic [24:0] closest_dist;
    logic        counted;
    logic [15:0] near_cnt;
    logic [15:0] coll_cnt;

    t_step_outcome outcome_q[$];
    t_step_outcome want;
    int fail_count = 0;
    int checked    = 0;
    int encounters = 0;
    int pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_encounters = encounters;

    function automatic logic [24:0] floor_root(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        for (int b = 25; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= radicand) root = probe;
        end
        return root[24:0];
    endfunction

    // Advance the encounter state by one position sample.
    function automatic t_step_outcome track_encounter(
        input logic               first,
        input logic               clear,
        input logic signed [23:0] xa,
        input logic signed [23:0] ya,
        input logic signed [23:0] xb,
        input logic signed [23:0] yb
    );
        longint        dx;
        longint        dy;
        longint        delta;
        longint        mag;
        logic [24:0]   span;
        logic          refresh;
        t_step_outcome res;
        dx = longint'(xa) - longint'(xb);
        dy = longint'(ya) - longint'(yb);
        span = floor_root(longint'(dx * dx + dy * dy));
        res.kind = cac_pkg::KIND_NONE;
        if (clear) begin
            near_cnt = '0;
            coll_cnt = '0;
        end
        if (first) begin
            prev_dist    = span;
            closest_dist = span;
            counted      = 1'b0;
        end else begin
            delta   = longint'(span) - longint'(prev_dist);
            mag     = (delta < 0) ? -delta : delta;
            refresh = (mag >= longint'(band));
            if (delta < -longint'(band)) begin
                closest_dist = span;
                counted      = 1'b0;
            end else if (delta > longint'(band)) begin
                // once counted, a receding step leaves the previous distance alone
                if (counted) begin
                    refresh = 1'b0;
                end else begin
                    if (closest_dist <= coll_limit) begin
                        if (coll_cnt != '1) coll_cnt++;
                        res.kind = cac_pkg::KIND_COLLISION;
                    end else if (closest_dist <= near_limit) begin
                        if (near_cnt != '1) near_cnt++;
                        res.kind = cac_pkg::KIND_NEAR_MISS;
                    end
                    counted = 1'b1;
                end
            end
            if (refresh) prev_dist = span;
        end
        res.separation      = span;
        res.near_total      = near_cnt;
        res.collision_total = coll_cnt;
        return res;
    endfunction

    task automatic report(input string field, input longint unsigned exp_v, got_v);
        if (fail_count < REPORT_CAP)
            $display("[%0t] result %0d: %s expected %0d, got %0d",
                     $time, checked, field, exp_v, got_v);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coll_limit   = DEFAULT_COLLISION;
            near_limit   = DEFAULT_NEAR_MISS;
            band         = DEFAULT_BAND;
            prev_dist    = '0;
            closest_dist = '0;
            counted      = 1'b0;
            near_cnt     = '0;
            coll_cnt     = '0;
            outcome_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    cac_pkg::REG_COLLISION_LIMIT: coll_limit = i_pwdata[24:0];
                    cac_pkg::REG_NEAR_MISS_LIMIT: near_limit = i_pwdata[24:0];
                    cac_pkg::REG_TREND_BAND:      band       = i_pwdata[24:0];
                    default: ;
                endcase
            end
            if (i_result_valid && i_result_ready) begin
                if (outcome_q.size() == 0) begin
                    report("unexpected item, separation", 0, i_separation);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_separation !== want.separation)
                        report("separation", want.separation, i_separation);
                    if (i_encounter_kind !== want.kind)
                        report("encounter_kind", want.kind, i_encounter_kind);
                    if (i_near_miss_total !== want.near_total)
                        report("near_miss_total", want.near_total, i_near_miss_total);
                    if (i_collision_total !== want.collision_total)
                        report("collision_total", want.collision_total, i_collision_total);
                    checked++;
                end
            end
            if (i_item_valid && i_item_ready) begin
                want = track_encounter(i_first_sample, i_clear_counts,
                                       i_xa, i_ya, i_xb, i_yb);
                if (want.kind != cac_pkg::KIND_NONE) encounters++;
                outcome_q = {outcome_q, want};
            end
        end
        pending <= outcome_q.size();
    end

endmodule

/* tb/closest_approach_encounter_counter_top_test.sv */
`timescale 1ns / 100ps

module closest_approach_encounter_counter_top_test;

    // Run length: about 1000 items, each allowing for its own work, the longest
    // sender gap ahead of it and the longest receiver stall behind it, then
    // taken about four times over.
    localparam int          CYCLE_LIMIT     = 400_000;
    localparam int          SETTLE_CYCLES   = 40;
    localparam int          PHASES          = 6;
    localparam int          ITEMS_PER_PHASE = 165;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic signed [23:0] MOST_NEG = 24'sh800000;
    localparam logic signed [23:0] MOST_POS = 24'sh7FFFFF;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [cac_pkg::CFG_ADDR_W-1:0] paddr;
    logic [cac_pkg::CFG_DATA_W-1:0] pwdata;
    logic [cac_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    int   fail_count;
    int   pending;
    int   checked;
    int   encounters;
    int   cycle_count   = 0;
    int   items_sent    = 0;
    int   settings_used = 0;
    int   burst_left    = 0;
    logic steady_sender = 1'b0;

    cac_in_if  #(.COORD_WIDTH(24))                   item_if ();
    cac_out_if #(.DIST_WIDTH(25), .COUNT_WIDTH(16))  result_if ();

    closest_approach_encounter_counter_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    closest_approach_encounter_counter_checker encounter_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (item_if.valid),
        .i_item_ready      (item_if.ready),
        .i_first_sample    (item_if.first_sample),
        .i_clear_counts    (item_if.clear_counts),
        .i_xa              (item_if.xa),
        .i_ya              (item_if.ya),
        .i_xb              (item_if.xb),
        .i_yb              (item_if.yb),
        .i_result_valid    (result_if.valid),
        .i_result_ready    (result_if.ready),
        .i_separation      (result_if.separation),
        .i_encounter_kind  (result_if.encounter_kind),
        .i_near_miss_total (result_if.near_miss_total),
        .i_collision_total (result_if.collision_total),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_encounters      (encounters)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block stops moving.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: a free-running stretch with ready held high, then a mix of
    // single-cycle drops and long holds, some longer than one item's work,
    // so the output register fills while the next item is being worked.
    initial begin
        int hold;
        int beat;
        hold = 0;
        beat = 0;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            beat++;
            if (beat % 3000 < 600) begin
                result_if.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                result_if.ready <= 1'b0;
            end else if ($urandom_range(0, 9) < 6) begin
                result_if.ready <= 1'b1;
            end else begin
                hold = $urandom_range(0, 40);
                result_if.ready <= 1'b0;
            end
        end
    end

    // One APB write: setup cycle, then access cycle; the register takes the
    // value at the edge that ends the access cycle.
    task automatic cfg_write(input logic [cac_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_limits(input logic [31:0] coll, near, tband);
        cfg_write(cac_pkg::REG_COLLISION_LIMIT, coll);
        cfg_write(cac_pkg::REG_NEAR_MISS_LIMIT, near);
        cfg_write(cac_pkg::REG_TREND_BAND, tband);
        settings_used++;
    endtask

    // Drop valid, wait out every expected result, then let the block settle.
    // The extra edge first lets an item taken at this very edge show up in
    // the outstanding count.
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender pacing: bursts of random length, random gaps between them.
    task automatic pace();
        if (!steady_sender) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                item_if.valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                burst_left = $urandom_range(0, 7);
            end
        end
    endtask

    // Present one sample and hold it until the block takes it.
    task automatic send_item(input logic first, clear,
                             input logic signed [23:0] xa, ya, xb, yb);
        item_if.valid        <= 1'b1;
        item_if.first_sample <= first;
        item_if.clear_counts <= clear;
        item_if.xa           <= xa;
        item_if.ya           <= ya;
        item_if.xb           <= xb;
        item_if.yb           <= yb;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        items_sent++;
        pace();
    endtask

    // Place vehicle B exactly gap east of a fixed point for vehicle A.
    task automatic send_east(input logic first, clear, input int gap);
        send_item(first, clear, 24'sd1000, -24'sd2000, 24'(1000 + gap), -24'sd2000);
    endtask

    // Place vehicle B about gap away from A in one of several directions.
    task automatic send_offset(input logic first, clear, input int bx, by, gap);
        int ox;
        int oy;
        case ($urandom_range(0, 5))
            0:       begin ox = gap;          oy = 0;           end
            1:       begin ox = -gap;         oy = 0;           end
            2:       begin ox = 0;            oy = gap;         end
            3:       begin ox = 0;            oy = -gap;        end
            4:       begin ox = gap * 3 / 5;  oy = gap * 4 / 5; end
            default: begin ox = -gap * 4 / 5; oy = gap * 3 / 5; end
        endcase
        send_item(first, clear, 24'(bx), 24'(by), 24'(bx + ox), 24'(by + oy));
    endtask

    // One pass of the two vehicles: close in to a minimum, then open up again.
    // Step sizes are sometimes tiny so the hysteresis band is straddled.
    task automatic run_encounter();
        int   bx;
        int   by;
        int   low;
        int   stride;
        int   down;
        int   up;
        int   d;
        logic fresh;
        bx = int'($urandom_range(0, 8_000_000)) - 4_000_000;
        by = int'($urandom_range(0, 8_000_000)) - 4_000_000;
        case ($urandom_range(0, 3))
            0:       low = $urandom_range(0, 600);
            1:       low = $urandom_range(0, 1500);
            2:       low = $urandom_range(0, 6000);
            default: low = $urandom_range(0, 3_000_000);
        endcase
        stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(20, 700);
        down   = $urandom_range(1, 6);
        up     = $urandom_range(1, 6);
        fresh  = ($urandom_range(0, 9) != 0);
        for (int i = down; i >= -up; i--) begin
            d = low + stride * ((i < 0) ? -i : i) + $urandom_range(0, 30);
            send_offset(fresh && (i == down), $urandom_range(0, 39) == 0, bx, by, d);
        end
    endtask

    // Noise: every field random over its full range.
    task automatic send_noise();
        send_item(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0,
                  24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    initial begin
        int   target;
        logic paused;
        paused  = 1'b0;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        item_if.valid        = 1'b0;
        item_if.first_sample = 1'b0;
        item_if.clear_counts = 1'b0;
        item_if.xa           = '0;
        item_if.ya           = '0;
        item_if.xb           = '0;
        item_if.yb           = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, on the reset thresholds (2 m, 4 m, band 26).
        // Start with no first sample: the step works from the zeroed state.
        send_east(1'b0, 1'b0, 0);
        // Receding from a zero closest distance counts a collision.
        send_east(1'b0, 1'b0, 300);
        // Coordinate extremes in both diagonals: the largest separation.
        send_item(1'b0, 1'b0, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS);
        send_item(1'b0, 1'b0, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
        send_item(1'b1, 1'b0, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
        // Close in to 400 and open up: collision, then a receding step after
        // the count, which must leave the previous distance where it was.
        send_east(1'b1, 1'b0, 2000);
        send_east(1'b0, 1'b0, 1500);
        send_east(1'b0, 1'b0, 1000);
        send_east(1'b0, 1'b0, 400);
        send_east(1'b0, 1'b0, 1000);
        send_east(1'b0, 1'b0, 1600);
        // Close in to 800, creep out by exactly the band twice, then recede:
        // near miss.
        send_east(1'b0, 1'b0, 800);
        send_east(1'b0, 1'b0, 826);
        send_east(1'b0, 1'b0, 852);
        send_east(1'b0, 1'b0, 900);
        // A pass that never gets inside either limit: counted as nothing.
        send_east(1'b1, 1'b0, 5000);
        send_east(1'b0, 1'b0, 3000);
        send_east(1'b0, 1'b0, 4000);
        // Clear the totals on a steady step, then on a counting step.
        send_east(1'b0, 1'b1, 4010);
        send_east(1'b1, 1'b0, 900);
        send_east(1'b0, 1'b0, 300);
        send_east(1'b0, 1'b1, 700);
        // Close in by exactly the band: steady, not approaching.
        send_east(1'b0, 1'b0, 674);
        send_east(1'b0, 1'b0, 600);

        // Random part: one threshold setting per phase, written while idle.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: apply_limits(32'd512, 32'd1024, 32'd26);
                // zero band: any change at all is a trend
                1: apply_limits(32'd0, ALL_ONES, 32'd0);
                // widest band: everything is steady
                2: apply_limits(32'd1200, 32'd2500, ALL_ONES);
                // collision limit above the near-miss limit
                3: apply_limits(32'd5000, 32'd1000, 32'd100);
                // random values with junk above the register width
                4: apply_limits($urandom_range(0, 6000) | ($urandom & 32'hFE00_0000),
                                $urandom_range(0, 8000) | ($urandom & 32'hFE00_0000),
                                $urandom_range(0, 300)  | ($urandom & 32'hFE00_0000));
                default: apply_limits(ALL_ONES, 32'd0, 32'd1);
            endcase
            // No sender gaps in one phase.
            steady_sender = (p == 3);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 15) send_noise();
                else run_encounter();
                // Hold off mid-phase until every result is back.
                if (p == 1 && !paused && items_sent >= target - ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        $display("Covered %0d items over %0d threshold settings; %0d results compared.",
                 items_sent, settings_used, checked);
        $display("Encounters counted along the way: %0d.", encounters);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/cac_pkg.sv
rtl/cac_in_if.sv
rtl/cac_out_if.sv
rtl/cac_root.sv
rtl/cac_track.sv
rtl/closest_approach_encounter_counter_top.sv
rtl/cac_checker.sv
tb/closest_approach_encounter_counter_checker.sv
tb/closest_approach_encounter_counter_top_test.sv
